FILE: rtl/itd_pkg.sv
// ----------------------------------------------------------------------------
// itd_pkg
// Shared widths, constants and controller/datapath types for the
// integer to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itd_pkg;

  localparam int VALUE_W    = 32;
  localparam int CAP_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = 4;
  localparam int QUOT_W     = 29;
  localparam int RECIP_SH   = 35;

  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CAP_W-1:0]   MIN_CAP    = 8'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CAP_W-1:0]          cap_t;
  typedef logic [CHAR_W-1:0]         char_t;
  typedef logic [DIGIT_W-1:0]        digit_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef struct packed {
    logic load;
    logic step;
    logic setup;
    logic advance;
  } itd_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic emit_last;
  } itd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/itd_if.sv
// ----------------------------------------------------------------------------
// itd_if
// Valid/ready channels carrying the conversion request and the text items.
// ----------------------------------------------------------------------------
`default_nettype none

interface itd_req_if;
  import itd_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  cap_t   capacity;

  modport source (output valid, output value, output capacity, input ready);
  modport sink   (input valid, input value, input capacity, output ready);
endinterface

interface itd_rsp_if;
  import itd_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_out;
  logic  char_valid;
  logic  last;
  logic  status;

  modport source (output valid, output char_out, output char_valid, output last,
                  output status, input ready);
  modport sink   (input valid, input char_out, input char_valid, input last,
                  input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/itd_ctrl.sv
// ----------------------------------------------------------------------------
// itd_ctrl
// Sequencer: accept, divide-by-ten digit loop, emit setup, item output.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output itd_pkg::itd_cmd_t cmd,
  input  itd_pkg::itd_stat_t stat
);
  import itd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SETUP,
    S_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load    = (state == S_IDLE) && in_valid && in_ready;
    cmd.step    = (state == S_CONV);
    cmd.setup   = (state == S_SETUP);
    cmd.advance = (state == S_EMIT) && out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_CONV;
            in_ready <= 1'b0;
          end
        end
        S_CONV: begin
          if (stat.quot_zero) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state     <= S_EMIT;
          out_valid <= 1'b1;
        end
        S_EMIT: begin
          if (out_valid && out_ready && stat.emit_last) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
          in_ready  <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itd_dp.sv
// ----------------------------------------------------------------------------
// itd_dp
// Datapath: magnitude register, reciprocal divide-by-ten, digit stack and
// output character selection.
// ----------------------------------------------------------------------------
`default_nettype none

module itd_dp (
  input  logic               clk,
  input  itd_pkg::itd_cmd_t  cmd,
  output itd_pkg::itd_stat_t stat,
  input  itd_pkg::value_t    in_value,
  input  itd_pkg::cap_t      in_capacity,
  output itd_pkg::char_t     char_out,
  output logic               char_valid,
  output logic               last,
  output logic               status
);
  import itd_pkg::*;

  logic [VALUE_W-1:0]   mag;
  logic                 neg;
  cap_t                 cap;
  cnt_t                 nd;
  cnt_t                 kept;
  logic                 trunc;
  logic                 sign_pend;
  logic                 err;
  digit_t               digits [MAX_DIGITS];

  logic [2*VALUE_W-1:0] prod;
  logic [QUOT_W-1:0]    quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;
  digit_t               rem;
  cap_t                 slots;
  cnt_t                 rd_idx;
  logic                 fin;

  // reciprocal divide by ten, exact for any 32-bit magnitude
  assign prod     = mag * RECIP_TEN;
  assign quot     = prod[2*VALUE_W-1:RECIP_SH];
  assign quot_x10 = ({3'b000, quot} << 3) + ({3'b000, quot} << 1);
  assign rem_full = mag - quot_x10;
  assign rem      = rem_full[DIGIT_W-1:0];

  assign slots  = cap - 8'd1 - {{(CAP_W-1){1'b0}}, neg};
  assign rd_idx = kept - 4'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= in_value[VALUE_W-1];
      mag <= in_value[VALUE_W-1] ? (~in_value + 32'd1) : in_value;
      cap <= in_capacity;
      nd  <= '0;
    end
    if (cmd.step) begin
      digits[nd[CNT_W-1:0]] <= rem;
      nd  <= nd + 4'd1;
      mag <= {3'b000, quot};
    end
    if (cmd.setup) begin
      kept      <= ({4'd0, nd} < slots) ? nd : slots[CNT_W-1:0];
      trunc     <= ({4'd0, nd} > slots);
      sign_pend <= neg;
      err       <= (cap < MIN_CAP);
    end
    if (cmd.advance) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        kept <= kept - 4'd1;
      end
    end
  end

  always_comb begin
    fin = err || (sign_pend ? (kept == 4'd0) : (kept == 4'd1));
    if (err) begin
      char_out = '0;
    end else if (sign_pend) begin
      char_out = CHAR_MINUS;
    end else begin
      char_out = CHAR_ZERO + {4'd0, digits[rd_idx]};
    end
    char_valid     = !err;
    last           = fin;
    status         = fin && (err || trunc);
    stat.quot_zero = (quot == '0);
    stat.emit_last = fin;
  end

endmodule

`default_nettype wire

FILE: rtl/int_to_decimal_text.sv
// ----------------------------------------------------------------------------
// int_to_decimal_text
// Signed 32-bit integer to decimal ASCII text, one character per item.
// ----------------------------------------------------------------------------
// One conversion at a time. After a request is taken, a single
// divide-by-ten unit (reciprocal multiply) produces one digit per cycle,
// 1 to 10 digits, then a setup state, then one result item per cycle
// while rsp.ready is high, 1 to 11 items. The next request is taken
// only after the final item has been accepted.
// A capacity below two gives one empty item with status set.
`default_nettype none

module int_to_decimal_text (
  input logic      clk,
  input logic      rst,
  itd_req_if.sink  req,
  itd_rsp_if.source rsp
);
  import itd_pkg::*;

  itd_cmd_t  cmd;
  itd_stat_t stat;

  itd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  itd_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .in_value    (req.value),
    .in_capacity (req.capacity),
    .char_out    (rsp.char_out),
    .char_valid  (rsp.char_valid),
    .last        (rsp.last),
    .status      (rsp.status)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while conversion in progress");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.last) |=> (req.ready && !rsp.valid))
    else $error("not idle after final item");

  a_empty_is_error: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.char_valid) |-> (rsp.last && rsp.status))
    else $error("empty item without error status");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> !rsp.status)
    else $error("status set before final item");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("output active while idle");

endmodule

`default_nettype wire
